@@ src/atlps_pkg.sv @@
// ----------------------------------------------------------------------------
// atlps_pkg
// shared types and constants of the thick line pixel shader: register map,
// fixed field widths and the sideband that rides along the root pipeline
// ----------------------------------------------------------------------------
package atlps_pkg;

    localparam int CRD_W  = 24;
    localparam int DBL_W  = CRD_W + 1;
    localparam int DM_W   = DBL_W + 1;
    localparam int HW_W   = 16;
    localparam int COL_W  = 32;
    localparam int CH_W   = 8;
    localparam int NUM_CH = 4;
    localparam int APB_AW = 5;
    localparam int APB_DW = 32;

    localparam logic [HW_W-1:0] LINE_WIDTH_RST = 16'd256;

    // cycles for the line setup registers to settle after a write
    localparam int GEO_LAT = 5;
    localparam int GEO_CW  = 3;

    typedef enum logic [2:0] {
        REG_START_X,
        REG_START_Y,
        REG_END_X,
        REG_END_Y,
        REG_LINE_WIDTH,
        REG_LINE_COLOR,
        REG_SOFT_ENDS,
        REG_HAS_ALPHA
    } reg_idx_t;

    // channel 3 red, 2 green, 1 blue, 0 alpha
    typedef logic [NUM_CH-1:0][CH_W-1:0] pix_t;

    typedef struct packed {
        logic hit;
        logic clamp_k;
        pix_t old;
    } atl_side_t;

endpackage

@@ src/atlps_isqrt.sv @@
// ----------------------------------------------------------------------------
// atlps_isqrt
// pipelined scaled root: largest k with k*k*q <= n, one result bit per stage,
// sideband travels with each item
// ----------------------------------------------------------------------------
module atlps_isqrt #(
    parameter int KW   = 17,
    parameter int NW   = 84,
    parameter int QW   = 52,
    parameter int SB_W = 34
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic [NW-1:0]   in_n,
    input  logic [QW-1:0]   in_q,
    input  logic [SB_W-1:0] in_sb,
    output logic            out_valid,
    output logic [KW-1:0]   out_k,
    output logic [SB_W-1:0] out_sb
);

    localparam int RW = ((NW > 2 * KW + QW) ? NW : 2 * KW + QW) + 2;

    logic            v_reg  [KW];
    logic [RW-1:0]   r_reg  [KW];
    logic [RW-1:0]   kq_reg [KW];
    logic [QW-1:0]   q_reg  [KW];
    logic [KW-1:0]   k_reg  [KW];
    logic [SB_W-1:0] sb_reg [KW];

    for (genvar s = 0; s < KW; s++)
    begin : g_stage
        localparam int B = KW - 1 - s;

        logic            v_prev;
        logic [RW-1:0]   r_prev;
        logic [RW-1:0]   kq_prev;
        logic [QW-1:0]   q_prev;
        logic [KW-1:0]   k_prev;
        logic [SB_W-1:0] sb_prev;
        logic [RW-1:0]   trial;
        logic [RW-1:0]   r_next;
        logic [RW-1:0]   kq_next;
        logic [KW-1:0]   k_next;

        if (s == 0)
        begin : g_first
            assign v_prev  = in_valid;
            assign r_prev  = RW'(in_n);
            assign kq_prev = '0;
            assign q_prev  = in_q;
            assign k_prev  = '0;
            assign sb_prev = in_sb;
        end
        else
        begin : g_rest
            assign v_prev  = v_reg[s-1];
            assign r_prev  = r_reg[s-1];
            assign kq_prev = kq_reg[s-1];
            assign q_prev  = q_reg[s-1];
            assign k_prev  = k_reg[s-1];
            assign sb_prev = sb_reg[s-1];
        end

        // (k + 2^b)^2 q = k^2 q + 2^(b+1) kq + 2^(2b) q
        always_comb
        begin
            trial = (kq_prev << (B + 1)) + (RW'(q_prev) << (2 * B));
            if (r_prev >= trial)
            begin
                r_next  = r_prev - trial;
                kq_next = kq_prev + (RW'(q_prev) << B);
                k_next  = k_prev | (KW'(1) << B);
            end
            else
            begin
                r_next  = r_prev;
                kq_next = kq_prev;
                k_next  = k_prev;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[s] <= 1'b0;
            end
            else
            begin
                v_reg[s] <= v_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            r_reg[s]  <= r_next;
            kq_reg[s] <= kq_next;
            q_reg[s]  <= q_prev;
            k_reg[s]  <= k_next;
            sb_reg[s] <= sb_prev;
        end
    end

    assign out_valid = v_reg[KW-1];
    assign out_k     = k_reg[KW-1];
    assign out_sb    = sb_reg[KW-1];

endmodule

@@ src/antialiased_thick_line_pixel_shader_top.sv @@
// ----------------------------------------------------------------------------
// antialiased_thick_line_pixel_shader_top
// from start to done a pixel passes registers p0 to p6, the root pipeline
//   (one result bit per stage, KW = max(16, FRAC_BITS+1) + 1 bits), then f1, f2, f3 and done
// takes one pixel per cycle while busy is low, results cannot be held off
// reset and every register write raise busy while the line setup
//   registers settle; reset leaves line_width 256, all else 0
// ----------------------------------------------------------------------------
module antialiased_thick_line_pixel_shader_top #(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [COORD_BITS-1:0]         pixel_x,
    input  logic [COORD_BITS-1:0]         pixel_y,
    input  logic [atlps_pkg::CH_W-1:0]    old_red,
    input  logic [atlps_pkg::CH_W-1:0]    old_green,
    input  logic [atlps_pkg::CH_W-1:0]    old_blue,
    input  logic [atlps_pkg::CH_W-1:0]    old_alpha,
    output logic                          done,
    output logic [atlps_pkg::CH_W-1:0]    new_red,
    output logic [atlps_pkg::CH_W-1:0]    new_green,
    output logic [atlps_pkg::CH_W-1:0]    new_blue,
    output logic [atlps_pkg::CH_W-1:0]    new_alpha,
    output logic                          touched,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [atlps_pkg::APB_AW-1:0]  paddr,
    input  logic [atlps_pkg::APB_DW-1:0]  pwdata,
    output logic [atlps_pkg::APB_DW-1:0]  prdata,
    output logic                          pready
);

    import atlps_pkg::*;

    localparam int UB   = FRAC_BITS + 1;
    localparam int U    = 1 << UB;
    localparam int IM_W = COORD_BITS + UB + 1;
    localparam int V_W  = ((IM_W > DBL_W) ? IM_W : DBL_W) + 1;
    localparam int BW   = V_W + 1;
    localparam int TW   = ((UB > HW_W) ? UB : HW_W) + 1;
    localparam int KW   = TW;
    localparam int PW   = DM_W + V_W;
    localparam int CW   = PW + 1;
    localparam int QW   = 2 * DM_W;
    localparam int TDW  = TW + DM_W;
    localparam int CMW  = (CW > TDW) ? CW : TDW;
    localparam int LTW  = (V_W > TW) ? V_W : TW;
    localparam int ACW  = TW + DM_W - 1;
    localparam int LO   = ACW / 2;
    localparam int HI   = ACW - LO;
    localparam int NW   = 2 * ACW;
    localparam int FW   = UB + 1;
    localparam int BLW  = CH_W + UB + 1;
    localparam int SB_W = $bits(atl_side_t);

    // ------------------------------------------------------------ registers
    logic [CRD_W-1:0]  cfg_start_x_reg;
    logic [CRD_W-1:0]  cfg_start_y_reg;
    logic [CRD_W-1:0]  cfg_end_x_reg;
    logic [CRD_W-1:0]  cfg_end_y_reg;
    logic [HW_W-1:0]   cfg_line_width_reg;
    pix_t              cfg_line_color_reg;
    logic              cfg_soft_ends_reg;
    logic              cfg_has_alpha_reg;
    logic              wr;
    logic [GEO_CW-1:0] geo_cnt_reg;
    logic [GEO_CW-1:0] geo_cnt_next;

    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_start_x_reg    <= '0;
            cfg_start_y_reg    <= '0;
            cfg_end_x_reg      <= '0;
            cfg_end_y_reg      <= '0;
            cfg_line_width_reg <= LINE_WIDTH_RST;
            cfg_line_color_reg <= '0;
            cfg_soft_ends_reg  <= 1'b0;
            cfg_has_alpha_reg  <= 1'b0;
        end
        else if (wr)
        begin
            case (reg_idx_t'(paddr[APB_AW-1:2]))
                REG_START_X:    cfg_start_x_reg    <= pwdata[CRD_W-1:0];
                REG_START_Y:    cfg_start_y_reg    <= pwdata[CRD_W-1:0];
                REG_END_X:      cfg_end_x_reg      <= pwdata[CRD_W-1:0];
                REG_END_Y:      cfg_end_y_reg      <= pwdata[CRD_W-1:0];
                REG_LINE_WIDTH: cfg_line_width_reg <= pwdata[HW_W-1:0];
                REG_LINE_COLOR: cfg_line_color_reg <= pwdata[COL_W-1:0];
                REG_SOFT_ENDS:  cfg_soft_ends_reg  <= pwdata[0];
                REG_HAS_ALPHA:  cfg_has_alpha_reg  <= pwdata[0];
                default:        cfg_has_alpha_reg  <= cfg_has_alpha_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx_t'(paddr[APB_AW-1:2]))
            REG_START_X:    prdata = APB_DW'(cfg_start_x_reg);
            REG_START_Y:    prdata = APB_DW'(cfg_start_y_reg);
            REG_END_X:      prdata = APB_DW'(cfg_end_x_reg);
            REG_END_Y:      prdata = APB_DW'(cfg_end_y_reg);
            REG_LINE_WIDTH: prdata = APB_DW'(cfg_line_width_reg);
            REG_LINE_COLOR: prdata = APB_DW'(cfg_line_color_reg);
            REG_SOFT_ENDS:  prdata = APB_DW'(cfg_soft_ends_reg);
            REG_HAS_ALPHA:  prdata = APB_DW'(cfg_has_alpha_reg);
            default:        prdata = '0;
        endcase
    end

    // settle counter, holds off new pixels while the setup chain catches up
    always_comb
    begin
        if (wr)
        begin
            geo_cnt_next = GEO_CW'(GEO_LAT);
        end
        else if (geo_cnt_reg != '0)
        begin
            geo_cnt_next = geo_cnt_reg - GEO_CW'(1);
        end
        else
        begin
            geo_cnt_next = geo_cnt_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            geo_cnt_reg <= GEO_CW'(GEO_LAT);
        end
        else
        begin
            geo_cnt_reg <= geo_cnt_next;
        end
    end

    assign busy = (geo_cnt_reg != '0);

    // ------------------------------------------------------------ line setup
    logic signed [DBL_W-1:0] sx2, sy2, ex2, ey2;
    logic signed [DM_W-1:0]  g_dx_reg, g_dy_reg, g_dx_next, g_dy_next;
    logic [DM_W-1:0]         adx, ady;
    logic                    dx_pos, dy_pos;
    logic                    g_xmaj_reg, g_xmaj_next, g_nz_reg, g_nz_next;
    logic signed [DBL_W-1:0] g_lm_reg, g_ln_reg, g_hm_reg, g_hn_reg;
    logic signed [DBL_W-1:0] g_lm_next, g_ln_next, g_hm_next, g_hn_next;
    logic signed [DM_W-1:0]  g_dm_reg, g_dn_reg, g_dm_next, g_dn_next;
    logic signed [BW-1:0]    g_lo_reg, g_hi_reg, g_lo_next, g_hi_next;
    logic signed [HW_W:0]    ew_s;
    logic [TW-1:0]           g_t_reg, g_t_next;
    logic signed [QW-1:0]    g_dm2_reg, g_dn2_reg, g_dm2_next, g_dn2_next;
    logic [TDW-1:0]          g_tdm_reg, g_tdm_next;
    logic [QW-1:0]           g_q_reg, g_q_next;

    assign sx2 = $signed({cfg_start_x_reg, 1'b0});
    assign sy2 = $signed({cfg_start_y_reg, 1'b0});
    assign ex2 = $signed({cfg_end_x_reg, 1'b0});
    assign ey2 = $signed({cfg_end_y_reg, 1'b0});

    assign g_dx_next = DM_W'(ex2) - DM_W'(sx2);
    assign g_dy_next = DM_W'(ey2) - DM_W'(sy2);

    always_comb
    begin
        adx         = g_dx_reg[DM_W-1] ? DM_W'(-g_dx_reg) : DM_W'(g_dx_reg);
        ady         = g_dy_reg[DM_W-1] ? DM_W'(-g_dy_reg) : DM_W'(g_dy_reg);
        dx_pos      = !g_dx_reg[DM_W-1] && (g_dx_reg != '0);
        dy_pos      = !g_dy_reg[DM_W-1] && (g_dy_reg != '0);
        g_xmaj_next = adx > ady;
        g_nz_next   = (g_dx_reg != '0) || (g_dy_reg != '0);
        if (g_xmaj_next)
        begin
            g_lm_next = dx_pos ? sx2 : ex2;
            g_ln_next = dx_pos ? sy2 : ey2;
            g_hm_next = dx_pos ? ex2 : sx2;
            g_hn_next = dx_pos ? ey2 : sy2;
        end
        else
        begin
            g_lm_next = dy_pos ? sy2 : ey2;
            g_ln_next = dy_pos ? sx2 : ex2;
            g_hm_next = dy_pos ? ey2 : sy2;
            g_hn_next = dy_pos ? ex2 : sx2;
        end
    end

    assign ew_s       = cfg_soft_ends_reg ? $signed({1'b0, cfg_line_width_reg}) : '0;
    assign g_dm_next  = DM_W'(g_hm_reg) - DM_W'(g_lm_reg);
    assign g_dn_next  = DM_W'(g_hn_reg) - DM_W'(g_ln_reg);
    assign g_lo_next  = BW'(g_lm_reg) - BW'(ew_s) - BW'(U);
    assign g_hi_next  = BW'(g_hm_reg) + BW'(ew_s) + BW'(U);
    assign g_t_next   = TW'(cfg_line_width_reg) + TW'(U);
    assign g_dm2_next = g_dm_reg * g_dm_reg;
    assign g_dn2_next = g_dn_reg * g_dn_reg;
    assign g_tdm_next = TDW'(g_t_reg) * TDW'($unsigned(g_dm_reg));
    assign g_q_next   = QW'($unsigned(g_dm2_reg)) + QW'($unsigned(g_dn2_reg));

    always_ff @(posedge clk)
    begin
        g_dx_reg   <= g_dx_next;
        g_dy_reg   <= g_dy_next;
        g_xmaj_reg <= g_xmaj_next;
        g_nz_reg   <= g_nz_next;
        g_lm_reg   <= g_lm_next;
        g_ln_reg   <= g_ln_next;
        g_hm_reg   <= g_hm_next;
        g_hn_reg   <= g_hn_next;
        g_dm_reg   <= g_dm_next;
        g_dn_reg   <= g_dn_next;
        g_lo_reg   <= g_lo_next;
        g_hi_reg   <= g_hi_next;
        g_t_reg    <= g_t_next;
        g_dm2_reg  <= g_dm2_next;
        g_dn2_reg  <= g_dn2_next;
        g_tdm_reg  <= g_tdm_next;
        g_q_reg    <= g_q_next;
    end

    // ------------------------------------------------------------ pixel pipe
    logic                    acc;
    logic                    p0_v_reg, p1_v_reg, p2_v_reg, p3_v_reg;
    logic                    p4_v_reg, p5_v_reg, p6_v_reg;
    logic [COORD_BITS-1:0]   p0_x_reg, p0_y_reg;
    pix_t                    p0_old_reg, p1_old_reg, p2_old_reg, p3_old_reg;
    pix_t                    p4_old_reg, p5_old_reg;
    pix_t                    in_old;

    assign acc    = start && !busy;
    assign in_old = {old_red, old_green, old_blue, old_alpha};

    // stage 1: major axis, offsets from both endpoints, scan range
    logic [COORD_BITS-1:0]   i_sel, j_sel;
    logic signed [IM_W-1:0]  im, jm;
    logic signed [V_W-1:0]   p1_vm_next, p1_vn_next, p1_wx_next, p1_wy_next;
    logic signed [V_W-1:0]   p1_vm_reg, p1_vn_reg, p1_wx_reg, p1_wy_reg;
    logic                    p1_inr_next, p1_inr_reg;

    assign i_sel       = g_xmaj_reg ? p0_x_reg : p0_y_reg;
    assign j_sel       = g_xmaj_reg ? p0_y_reg : p0_x_reg;
    assign im          = $signed({1'b0, i_sel, {UB{1'b0}}});
    assign jm          = $signed({1'b0, j_sel, {UB{1'b0}}});
    assign p1_vm_next  = V_W'(im) - V_W'(g_lm_reg);
    assign p1_vn_next  = V_W'(jm) - V_W'(g_ln_reg);
    assign p1_wx_next  = V_W'(im) - V_W'(g_hm_reg);
    assign p1_wy_next  = V_W'(jm) - V_W'(g_hn_reg);
    assign p1_inr_next = (BW'(im) > g_lo_reg) && (BW'(im) < g_hi_reg);

    // stage 2: cross and dot products
    logic signed [PW-1:0]    p2_m1_next, p2_m2_next, p2_m3_next, p2_m4_next;
    logic signed [PW-1:0]    p2_m1_reg, p2_m2_reg, p2_m3_reg, p2_m4_reg;
    logic signed [V_W-1:0]   p2_vm_reg, p2_vn_reg, p2_wx_reg, p2_wy_reg;
    logic                    p2_inr_reg;

    assign p2_m1_next = g_dm_reg * p1_vn_reg;
    assign p2_m2_next = g_dn_reg * p1_vm_reg;
    assign p2_m3_next = g_dm_reg * p1_vm_reg;
    assign p2_m4_next = g_dn_reg * p1_vn_reg;

    // stage 3: sums, endpoint offset magnitudes
    logic signed [CW-1:0]    p3_c_next, p3_p_next, p3_c_reg, p3_p_reg;
    logic [V_W-1:0]          p3_avm_next, p3_avn_next, p3_awx_next, p3_awy_next;
    logic [V_W-1:0]          p3_avm_reg, p3_avn_reg, p3_awx_reg, p3_awy_reg;
    logic                    p3_inr_reg;

    assign p3_c_next   = CW'(p2_m1_reg) - CW'(p2_m2_reg);
    assign p3_p_next   = CW'(p2_m3_reg) + CW'(p2_m4_reg);
    assign p3_avm_next = p2_vm_reg[V_W-1] ? V_W'(-p2_vm_reg) : V_W'(p2_vm_reg);
    assign p3_avn_next = p2_vn_reg[V_W-1] ? V_W'(-p2_vn_reg) : V_W'(p2_vn_reg);
    assign p3_awx_next = p2_wx_reg[V_W-1] ? V_W'(-p2_wx_reg) : V_W'(p2_wx_reg);
    assign p3_awy_next = p2_wy_reg[V_W-1] ? V_W'(-p2_wy_reg) : V_W'(p2_wy_reg);

    // stage 4: |c|, segment side, endpoint limits
    logic [CW-1:0]           p4_ac_next, p4_ac_reg;
    logic signed [CW-1:0]    q_ext;
    logic                    p4_pneg_next, p4_pgt_next, p4_pneg_reg, p4_pgt_reg;
    logic                    p4_lvm_next, p4_lvn_next, p4_lwx_next, p4_lwy_next;
    logic                    p4_lvm_reg, p4_lvn_reg, p4_lwx_reg, p4_lwy_reg;
    logic [V_W-1:0]          p4_avm_reg, p4_avn_reg, p4_awx_reg, p4_awy_reg;
    logic                    p4_inr_reg;

    assign q_ext        = $signed(CW'(g_q_reg));
    assign p4_ac_next   = p3_c_reg[CW-1] ? CW'(-p3_c_reg) : CW'(p3_c_reg);
    assign p4_pneg_next = p3_p_reg[CW-1];
    assign p4_pgt_next  = p3_p_reg > q_ext;
    assign p4_lvm_next  = LTW'(p3_avm_reg) < LTW'(g_t_reg);
    assign p4_lvn_next  = LTW'(p3_avn_reg) < LTW'(g_t_reg);
    assign p4_lwx_next  = LTW'(p3_awx_reg) < LTW'(g_t_reg);
    assign p4_lwy_next  = LTW'(p3_awy_reg) < LTW'(g_t_reg);

    // stage 5: touch decision, squares as partial products
    logic                    p5_hit_next, p5_hit_reg, p5_endp_next, p5_endp_reg;
    logic                    p5_big_next, p5_big_reg;
    logic [V_W-1:0]          wx_sel, wy_sel;
    logic [2*TW-1:0]         p5_sqx_next, p5_sqy_next, p5_sqx_reg, p5_sqy_reg;
    logic [HI-1:0]           ac_h;
    logic [LO-1:0]           ac_l;
    logic [2*HI-1:0]         p5_hh_next, p5_hh_reg;
    logic [HI+LO-1:0]        p5_hl_next, p5_hl_reg;
    logic [2*LO-1:0]         p5_ll_next, p5_ll_reg;

    always_comb
    begin
        p5_endp_next = p4_pneg_reg || p4_pgt_reg;
        p5_hit_next  = g_nz_reg && p4_inr_reg && (CMW'(p4_ac_reg) < CMW'(g_tdm_reg))
                       && (!p5_endp_next || cfg_soft_ends_reg);
        wx_sel       = p4_pneg_reg ? p4_avm_reg : p4_awx_reg;
        wy_sel       = p4_pneg_reg ? p4_avn_reg : p4_awy_reg;
        p5_big_next  = !((p4_pneg_reg ? p4_lvm_reg : p4_lwx_reg)
                         && (p4_pneg_reg ? p4_lvn_reg : p4_lwy_reg));
        p5_sqx_next  = (2*TW)'(wx_sel[TW-1:0]) * (2*TW)'(wx_sel[TW-1:0]);
        p5_sqy_next  = (2*TW)'(wy_sel[TW-1:0]) * (2*TW)'(wy_sel[TW-1:0]);
        ac_h         = p4_ac_reg[ACW-1:LO];
        ac_l         = p4_ac_reg[LO-1:0];
        p5_hh_next   = (2*HI)'(ac_h) * (2*HI)'(ac_h);
        p5_hl_next   = (HI+LO)'(ac_h) * (HI+LO)'(ac_l);
        p5_ll_next   = (2*LO)'(ac_l) * (2*LO)'(ac_l);
    end

    // stage 6: operands of the root
    logic [NW-1:0]           p6_n_next, p6_n_reg;
    logic [QW-1:0]           p6_q_next, p6_q_reg;
    atl_side_t               p6_sb_next, p6_sb_reg;

    always_comb
    begin
        if (p5_endp_reg)
        begin
            p6_n_next = NW'(p5_sqx_reg) + NW'(p5_sqy_reg);
            p6_q_next = QW'(1);
        end
        else
        begin
            p6_n_next = (NW'(p5_hh_reg) << (2 * LO)) + (NW'(p5_hl_reg) << (LO + 1))
                        + NW'(p5_ll_reg);
            p6_q_next = g_q_reg;
        end
        p6_sb_next.hit     = p5_hit_reg;
        p6_sb_next.clamp_k = p5_endp_reg && p5_big_reg;
        p6_sb_next.old     = p5_old_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p0_v_reg <= 1'b0;
            p1_v_reg <= 1'b0;
            p2_v_reg <= 1'b0;
            p3_v_reg <= 1'b0;
            p4_v_reg <= 1'b0;
            p5_v_reg <= 1'b0;
            p6_v_reg <= 1'b0;
        end
        else
        begin
            p0_v_reg <= acc;
            p1_v_reg <= p0_v_reg;
            p2_v_reg <= p1_v_reg;
            p3_v_reg <= p2_v_reg;
            p4_v_reg <= p3_v_reg;
            p5_v_reg <= p4_v_reg;
            p6_v_reg <= p5_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        p0_x_reg    <= pixel_x;
        p0_y_reg    <= pixel_y;
        p0_old_reg  <= in_old;
        p1_vm_reg   <= p1_vm_next;
        p1_vn_reg   <= p1_vn_next;
        p1_wx_reg   <= p1_wx_next;
        p1_wy_reg   <= p1_wy_next;
        p1_inr_reg  <= p1_inr_next;
        p1_old_reg  <= p0_old_reg;
        p2_m1_reg   <= p2_m1_next;
        p2_m2_reg   <= p2_m2_next;
        p2_m3_reg   <= p2_m3_next;
        p2_m4_reg   <= p2_m4_next;
        p2_vm_reg   <= p1_vm_reg;
        p2_vn_reg   <= p1_vn_reg;
        p2_wx_reg   <= p1_wx_reg;
        p2_wy_reg   <= p1_wy_reg;
        p2_inr_reg  <= p1_inr_reg;
        p2_old_reg  <= p1_old_reg;
        p3_c_reg    <= p3_c_next;
        p3_p_reg    <= p3_p_next;
        p3_avm_reg  <= p3_avm_next;
        p3_avn_reg  <= p3_avn_next;
        p3_awx_reg  <= p3_awx_next;
        p3_awy_reg  <= p3_awy_next;
        p3_inr_reg  <= p2_inr_reg;
        p3_old_reg  <= p2_old_reg;
        p4_ac_reg   <= p4_ac_next;
        p4_pneg_reg <= p4_pneg_next;
        p4_pgt_reg  <= p4_pgt_next;
        p4_lvm_reg  <= p4_lvm_next;
        p4_lvn_reg  <= p4_lvn_next;
        p4_lwx_reg  <= p4_lwx_next;
        p4_lwy_reg  <= p4_lwy_next;
        p4_avm_reg  <= p3_avm_reg;
        p4_avn_reg  <= p3_avn_reg;
        p4_awx_reg  <= p3_awx_reg;
        p4_awy_reg  <= p3_awy_reg;
        p4_inr_reg  <= p3_inr_reg;
        p4_old_reg  <= p3_old_reg;
        p5_hit_reg  <= p5_hit_next;
        p5_endp_reg <= p5_endp_next;
        p5_big_reg  <= p5_big_next;
        p5_sqx_reg  <= p5_sqx_next;
        p5_sqy_reg  <= p5_sqy_next;
        p5_hh_reg   <= p5_hh_next;
        p5_hl_reg   <= p5_hl_next;
        p5_ll_reg   <= p5_ll_next;
        p5_old_reg  <= p4_old_reg;
        p6_n_reg    <= p6_n_next;
        p6_q_reg    <= p6_q_next;
        p6_sb_reg   <= p6_sb_next;
    end

    // ------------------------------------------------------------ root
    logic            sq_v;
    logic [KW-1:0]   sq_k;
    logic [SB_W-1:0] sq_sb;

    atlps_isqrt #(
        .KW   (KW),
        .NW   (NW),
        .QW   (QW),
        .SB_W (SB_W)
    ) u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (p6_v_reg),
        .in_n      (p6_n_reg),
        .in_q      (p6_q_reg),
        .in_sb     (p6_sb_reg),
        .out_valid (sq_v),
        .out_k     (sq_k),
        .out_sb    (sq_sb)
    );

    // ------------------------------------------------------------ coverage and blend
    atl_side_t               sq_side;
    logic                    f1_v_reg, f2_v_reg, f3_v_reg, done_reg;
    logic [TW-1:0]           f1_k_next, f1_k_reg;
    atl_side_t               f1_sb_reg, f2_sb_reg, f3_sb_reg;
    logic signed [TW:0]      fd;
    logic [FW-1:0]           f2_f_next, f2_f_reg;
    logic [NUM_CH-1:0][BLW-1:0] f3_po_next, f3_pc_next, f3_po_reg, f3_pc_reg;
    logic [BLW-1:0]          bl_sum [NUM_CH];
    pix_t                    out_next, out_reg;
    logic                    touched_reg;

    assign sq_side   = atl_side_t'(sq_sb);
    assign f1_k_next = sq_side.clamp_k ? g_t_reg
                       : ((TW'(sq_k) < g_t_reg) ? TW'(sq_k) : g_t_reg);

    always_comb
    begin
        fd = $signed({1'b0, f1_k_reg}) - $signed((TW+1)'(cfg_line_width_reg));
        if (fd[TW])
        begin
            f2_f_next = '0;
        end
        else if (fd > $signed((TW+1)'(U)))
        begin
            f2_f_next = FW'(U);
        end
        else
        begin
            f2_f_next = FW'(fd);
        end
    end

    always_comb
    begin
        for (int n = 0; n < NUM_CH; n++)
        begin
            f3_po_next[n] = BLW'(f2_sb_reg.old[n]) * BLW'(f2_f_reg);
            f3_pc_next[n] = BLW'(cfg_line_color_reg[n]) * (BLW'(U) - BLW'(f2_f_reg));
        end
    end

    always_comb
    begin
        for (int n = 0; n < NUM_CH; n++)
        begin
            bl_sum[n] = f3_po_reg[n] + f3_pc_reg[n] + BLW'(U / 2);
            if (f3_sb_reg.hit && ((n != 0) || cfg_has_alpha_reg))
            begin
                out_next[n] = bl_sum[n][UB+CH_W-1:UB];
            end
            else
            begin
                out_next[n] = f3_sb_reg.old[n];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_v_reg <= 1'b0;
            f2_v_reg <= 1'b0;
            f3_v_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            f1_v_reg <= sq_v;
            f2_v_reg <= f1_v_reg;
            f3_v_reg <= f2_v_reg;
            done_reg <= f3_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        f1_k_reg    <= f1_k_next;
        f1_sb_reg   <= sq_side;
        f2_f_reg    <= f2_f_next;
        f2_sb_reg   <= f1_sb_reg;
        f3_po_reg   <= f3_po_next;
        f3_pc_reg   <= f3_pc_next;
        f3_sb_reg   <= f2_sb_reg;
        out_reg     <= out_next;
        touched_reg <= f3_sb_reg.hit;
    end

    assign done      = done_reg;
    assign new_red   = out_reg[3];
    assign new_green = out_reg[2];
    assign new_blue  = out_reg[1];
    assign new_alpha = out_reg[0];
    assign touched   = touched_reg;

    // ------------------------------------------------------------ checks
    a_wr_busy : assert property (@(posedge clk) disable iff (!rst_n)
        wr |=> busy)
        else $error("register write did not hold off new pixels");

    a_cnt_range : assert property (@(posedge clk) disable iff (!rst_n)
        geo_cnt_reg <= GEO_CW'(GEO_LAT))
        else $error("settle counter out of range");

    a_cov_range : assert property (@(posedge clk) disable iff (!rst_n)
        f2_v_reg |-> (f2_f_reg <= FW'(U)))
        else $error("coverage above one");

    a_hit_line : assert property (@(posedge clk) disable iff (!rst_n)
        (done && touched) |-> g_nz_reg)
        else $error("pixel touched by a zero-length line");

endmodule
